>>> rtl/arp_pkg.sv
// arp_pkg: shared types and constants of the note arpeggiator
// payload structs, command codes, mode codes, controller/datapath structs
// no dependencies
package arp_pkg;

  localparam int RAND_W     = 16;
  localparam int NOTE_W     = 7;
  localparam int PITCH_W    = 8;
  localparam int OCT_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  // input commands
  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // arp modes
  localparam logic [2:0] MODE_SINGLE = 3'd0;
  localparam logic [2:0] MODE_UP     = 3'd1;
  localparam logic [2:0] MODE_DOWN   = 3'd2;
  localparam logic [2:0] MODE_BOUNCE = 3'd3;
  localparam logic [2:0] MODE_ALT    = 3'd4;
  localparam logic [2:0] MODE_RANDOM = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ARP_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCT_RANGE = 1'd1;

  localparam logic [PITCH_W-1:0] OCT_STEP   = 8'd12;
  localparam logic [OCT_W-1:0]   BOUNCE_TOP = 4'd8;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [NOTE_W-1:0] note;
    logic [RAND_W-1:0] random_octave;
    logic [RAND_W-1:0] random_pick;
  } arp_in_t;

  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic               release_res;
  } arp_out_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_NEWEST,
    RD_IDX
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    scan_clr;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    k_inc;
    logic    press_add;
    logic    rel_keep;
    logic    rel_fin;
    logic    ss_take;
    logic    ss_clear;
    logic    arp_clear;
    logic    arp_adv;
    logic    div_go_oct;
    logic    div_go_pick;
    logic    oct_zero;
    logic    oct_take;
    logic    rnd_commit;
    logic    emit_note;
    logic    emit_rel;
  } arp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] cmd;
    logic       count_zero;
    logic       k_last;
    logic       match;
    logic       newest_diff;
    logic       range_zero;
    logic       div_busy;
    logic       out_free;
  } arp_stat_t;

endpackage

>>> rtl/arp_div.sv
// arp_div: iterative restoring remainder unit, one dividend bit per cycle
// depends on arp_pkg
module arp_div #(
  parameter int DIV_W = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [arp_pkg::RAND_W-1:0] dividend,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      busy,
  output logic [DIV_W-1:0]          rem
);
  import arp_pkg::*;

  localparam int CNT_W = $clog2(RAND_W);

  logic [CNT_W-1:0]  cnt;
  logic [RAND_W-1:0] sh;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    trial;

  assign trial = {rem, sh[RAND_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(RAND_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      sh <= {sh[RAND_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= DIV_W'(trial - {1'b0, dvs});
      end else begin
        rem <= DIV_W'(trial);
      end
    end
  end

endmodule

>>> rtl/arp_dp.sv
// arp_dp: datapath of the note arpeggiator
// held-note memory, step/octave state, config registers, output register
// depends on arp_pkg and arp_div
module arp_dp #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  arp_pkg::arp_cmd_t             ctl,
  output arp_pkg::arp_stat_t            stat,
  input  arp_pkg::arp_in_t              in_data,
  input  logic                          cfg_we,
  input  logic [arp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arp_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output arp_pkg::arp_out_t             out_data
);
  import arp_pkg::*;

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int DW = (CW > 3) ? CW : 3;

  arp_in_t           in_r;
  logic [2:0]        mode;
  logic [2:0]        range_r;
  logic [NOTE_W-1:0] mem [LIST_DEPTH];
  logic [NOTE_W-1:0] rdata;
  logic [CW-1:0]     count;
  logic [CW-1:0]     step;
  logic [OCT_W-1:0]  oct;
  logic              down;
  logic [IW-1:0]     last_pick;
  logic              parity;
  logic [NOTE_W-1:0] sounding;
  logic [CW-1:0]     k;
  logic [CW-1:0]     w;
  logic [IW-1:0]     idx_r;
  logic              lift;
  logic [OCT_W-1:0]  rnd_oct;

  logic              full;
  logic              keep;
  logic [IW-1:0]     raddr;
  logic              mem_we;
  logic [IW-1:0]     waddr;
  logic [NOTE_W-1:0] wdata;
  logic              div_busy;
  logic [DW-1:0]     div_rem;
  logic [OCT_W-1:0]  range4;

  // advance terms
  logic              pass;
  logic [CW-1:0]     step_w;
  logic [OCT_W-1:0]  oct_inc;
  logic [OCT_W-1:0]  oct_dec;
  logic [OCT_W-1:0]  bnc;
  logic [OCT_W-1:0]  oct_n;
  logic              down_n;
  logic              parity_n;
  logic [CW-1:0]     idx_full;
  logic              lift_n;

  // random terms
  logic [CW-1:0]     pick;
  logic [CW-1:0]     pick_inc;
  logic [CW-1:0]     pick_sel;
  logic              multi;

  logic [OCT_W-1:0]  eff_oct;
  logic [PITCH_W-1:0] pitch_c;

  assign full   = (count == CW'(LIST_DEPTH));
  assign keep   = (rdata != in_r.note);
  assign range4 = {1'b0, range_r};
  assign multi  = (count > CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_SINGLE;
      range_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ARP_MODE:  mode <= cfg_data;
        CFG_OCT_RANGE: range_r <= cfg_data;
        default: ;
      endcase
    end
  end

  arp_div #(.DIV_W(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_go_oct | ctl.div_go_pick),
    .dividend (ctl.div_go_oct ? in_r.random_octave : in_r.random_pick),
    .divisor  (ctl.div_go_oct ? DW'(range_r) : DW'(count)),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  always_comb begin
    case (ctl.rd_sel)
      RD_SCAN:   raddr = k[IW-1:0];
      RD_NEWEST: raddr = IW'(count - 1'b1);
      RD_IDX:    raddr = idx_r;
      default:   raddr = idx_r;
    endcase
  end

  assign mem_we = (ctl.press_add && !full) || (ctl.rel_keep && keep);
  assign waddr  = ctl.press_add ? count[IW-1:0] : w[IW-1:0];
  assign wdata  = ctl.press_add ? in_r.note : rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // one arp step of the walking modes
  always_comb begin
    pass     = (step >= count);
    step_w   = pass ? '0 : step;
    oct_inc  = oct + 1'b1;
    oct_dec  = oct - 1'b1;
    oct_n    = oct;
    down_n   = down;
    bnc      = down ? oct_dec : oct_inc;
    if (pass) begin
      case (mode)
        MODE_UP, MODE_ALT: begin
          oct_n = (oct_inc > range4) ? '0 : oct_inc;
        end
        MODE_DOWN: begin
          oct_n = (oct == '0) ? range4 : oct_dec;
        end
        MODE_BOUNCE: begin
          if (bnc > BOUNCE_TOP) begin
            bnc = '0;
          end
          oct_n = bnc;
          if (bnc > range4) begin
            down_n = 1'b1;
          end
          if (bnc == '0) begin
            down_n = 1'b0;
          end
        end
        default: ;
      endcase
    end
    parity_n = (mode == MODE_ALT) ? ~parity : parity;
    idx_full = ((mode != MODE_ALT) && down_n) ? (count - 1'b1 - step_w) : step_w;
    if (mode == MODE_ALT) begin
      lift_n = (count == CW'(1)) ? parity_n : step_w[0];
    end else begin
      lift_n = 1'b1;
    end
  end

  // random pick with repeat avoidance
  always_comb begin
    pick     = CW'(div_rem);
    pick_inc = pick + 1'b1;
    pick_sel = pick;
    if (multi && (pick == CW'(last_pick))) begin
      pick_sel = (pick_inc == count) ? '0 : pick_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      step      <= '0;
      oct       <= '0;
      down      <= 1'b0;
      last_pick <= '0;
      parity    <= 1'b0;
      sounding  <= '0;
      k         <= '0;
      w         <= '0;
      idx_r     <= '0;
      lift      <= 1'b1;
      rnd_oct   <= '0;
    end else begin
      if (ctl.scan_clr) begin
        k <= '0;
        w <= '0;
      end
      if (ctl.k_inc) begin
        k <= k + 1'b1;
      end
      if (ctl.rel_keep && keep) begin
        w <= w + 1'b1;
      end
      if (ctl.rel_fin) begin
        count <= w;
      end
      if (ctl.press_add && !full) begin
        count <= count + 1'b1;
      end
      if (ctl.ss_take) begin
        sounding <= rdata;
      end
      if (ctl.ss_clear) begin
        sounding <= '0;
      end
      if (ctl.arp_clear) begin
        step <= '0;
        oct  <= '0;
        down <= 1'b0;
      end
      if (ctl.arp_adv) begin
        step   <= step_w + 1'b1;
        oct    <= oct_n;
        down   <= down_n;
        parity <= parity_n;
        idx_r  <= idx_full[IW-1:0];
        lift   <= lift_n;
      end
      if (ctl.oct_zero) begin
        rnd_oct <= '0;
      end
      if (ctl.oct_take) begin
        rnd_oct <= OCT_W'(div_rem);
      end
      if (ctl.rnd_commit) begin
        if (multi) begin
          last_pick <= pick_sel[IW-1:0];
        end
        step  <= pick_sel;
        oct   <= rnd_oct;
        idx_r <= pick_sel[IW-1:0];
        lift  <= 1'b1;
      end
    end
  end

  assign eff_oct = ((mode == MODE_ALT) && !lift) ? '0 : oct;
  assign pitch_c = {1'b0, rdata} + OCT_STEP * {{(PITCH_W - OCT_W){1'b0}}, eff_oct};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit_note || ctl.emit_rel) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_note) begin
      out_data.pitch       <= pitch_c;
      out_data.release_res <= 1'b0;
    end else if (ctl.emit_rel) begin
      out_data.pitch       <= '0;
      out_data.release_res <= 1'b1;
    end
  end

  always_comb begin
    stat.mode        = mode;
    stat.cmd         = in_r.cmd;
    stat.count_zero  = (count == '0);
    stat.k_last      = (CW'(k + 1'b1) == count);
    stat.match       = (rdata == in_r.note);
    stat.newest_diff = (rdata != sounding);
    stat.range_zero  = (range_r == '0);
    stat.div_busy    = div_busy;
    stat.out_free    = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(LIST_DEPTH))
    else $error("held count above list depth");

  a_release_zero: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit_rel) |=> (out_valid && out_data.release_res && out_data.pitch == '0))
    else $error("release result carries a pitch");

  a_oct_bound: assert property (@(posedge clk) disable iff (rst)
    oct <= BOUNCE_TOP)
    else $error("octave offset out of range");

  a_press_grow: assert property (@(posedge clk) disable iff (rst)
    (ctl.press_add && !full) |=> (count == $past(count) + 1'b1))
    else $error("press did not grow the list");
`endif

endmodule

>>> rtl/arp_ctrl.sv
// arp_ctrl: sequencing state machine of the note arpeggiator
// drives arp_dp through command/status structs; depends on arp_pkg
module arp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_cmd,
  output logic               in_ready,
  input  arp_pkg::arp_stat_t stat,
  output arp_pkg::arp_cmd_t  ctl
);
  import arp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P_RD,
    S_P_CHK,
    S_P_ADD,
    S_R_RD,
    S_R_CHK,
    S_R_FIN,
    S_POST,
    S_SS_CHK,
    S_ADV,
    S_DIV_O,
    S_DIV_P,
    S_RD_IDX,
    S_EMIT_NOTE,
    S_EMIT_REL
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.latch    = 1'b1;
          ctl.scan_clr = 1'b1;
          case (in_cmd)
            CMD_PRESS:   state_next = stat.count_zero ? S_P_ADD : S_P_RD;
            CMD_RELEASE: state_next = stat.count_zero ? S_POST : S_R_RD;
            CMD_TICK:    state_next = S_POST;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_P_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_SCAN;
        state_next = S_P_CHK;
      end
      S_P_CHK: begin
        if (stat.match) begin
          state_next = S_POST;
        end else begin
          ctl.k_inc  = 1'b1;
          state_next = stat.k_last ? S_P_ADD : S_P_RD;
        end
      end
      S_P_ADD: begin
        ctl.press_add = 1'b1;
        state_next    = S_POST;
      end
      S_R_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_SCAN;
        state_next = S_R_CHK;
      end
      S_R_CHK: begin
        ctl.rel_keep = 1'b1;
        ctl.k_inc    = 1'b1;
        state_next   = stat.k_last ? S_R_FIN : S_R_RD;
      end
      S_R_FIN: begin
        ctl.rel_fin = 1'b1;
        state_next  = S_POST;
      end
      S_POST: begin
        if (stat.mode == MODE_SINGLE) begin
          if (stat.count_zero) begin
            ctl.ss_clear = 1'b1;
            state_next   = (stat.cmd == CMD_RELEASE) ? S_EMIT_REL : S_IDLE;
          end else begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = RD_NEWEST;
            state_next = S_SS_CHK;
          end
        end else if (stat.mode > MODE_RANDOM) begin
          state_next = S_IDLE;
        end else if (stat.count_zero) begin
          ctl.arp_clear = (stat.mode != MODE_RANDOM);
          state_next    = S_IDLE;
        end else if (stat.cmd != CMD_TICK) begin
          state_next = S_IDLE;
        end else if (stat.mode == MODE_RANDOM) begin
          if (stat.range_zero) begin
            ctl.oct_zero    = 1'b1;
            ctl.div_go_pick = 1'b1;
            state_next      = S_DIV_P;
          end else begin
            ctl.div_go_oct = 1'b1;
            state_next     = S_DIV_O;
          end
        end else begin
          state_next = S_ADV;
        end
      end
      S_SS_CHK: begin
        if (stat.newest_diff) begin
          ctl.ss_take = 1'b1;
          state_next  = S_EMIT_NOTE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ADV: begin
        ctl.arp_adv = 1'b1;
        state_next  = S_RD_IDX;
      end
      S_DIV_O: begin
        if (!stat.div_busy) begin
          ctl.oct_take    = 1'b1;
          ctl.div_go_pick = 1'b1;
          state_next      = S_DIV_P;
        end
      end
      S_DIV_P: begin
        if (!stat.div_busy) begin
          ctl.rnd_commit = 1'b1;
          state_next     = S_RD_IDX;
        end
      end
      S_RD_IDX: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_IDX;
        state_next = S_EMIT_NOTE;
      end
      S_EMIT_NOTE: begin
        if (stat.out_free) begin
          ctl.emit_note = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_EMIT_REL: begin
        if (stat.out_free) begin
          ctl.emit_rel = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

>>> rtl/note_arpeggiator.sv
// note_arpeggiator: top level, held-note list plus arp pattern generator
// instantiates arp_ctrl and arp_dp; depends on arp_pkg
//
//   channel  direction  handshake               payload
//   in       to block   in_valid / in_ready     in_data  (arp_in_t)
//   out      from block out_valid / out_ready   out_data (arp_out_t)
//   cfg      to block   cfg_we                  cfg_index, cfg_data
//
// one item at a time; a transfer in is followed by its list work
// press: a read and a check per held key scanned, then the add, plus a newest-note read in single shot
// release: a read and a keep step per held key (compaction reads and rewrites the list), plus the single-shot result
// tick in walking modes: advance, read, emit; random mode runs two remainders over the 16-bit inputs, one at range 0
// synchronous reset clears control state; list memory needs no clearing pass
// a result waits in the output register; a new item is taken meanwhile,
// and the block only stalls if a second result is due before the first leaves
module note_arpeggiator #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  arp_pkg::arp_in_t              in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output arp_pkg::arp_out_t             out_data,
  // register writes
  input  logic                          cfg_we,
  input  logic [arp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import arp_pkg::*;

  // command and status between sequencer and datapath
  arp_cmd_t  ctl;
  arp_stat_t stat;

  // sequencer: list scan, compaction, mode dispatch, emit wait
  arp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // datapath: note memory, octave/step state, remainder unit, output register
  arp_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
